>>> hw/rtl/gbf_pkg.sv
// ----------------------------------------------------------------------------
// gbf_pkg
// Shared types, codes and helpers of the glyph blit frame buffer block.
// ----------------------------------------------------------------------------
package gbf_pkg;

  // Request type codes
  localparam logic [2:0] REQ_LOAD_DESC  = 3'd0;
  localparam logic [2:0] REQ_LOAD_GLYPH = 3'd1;
  localparam logic [2:0] REQ_SET_CURSOR = 3'd2;
  localparam logic [2:0] REQ_DRAW       = 3'd3;
  localparam logic [2:0] REQ_CLEAR      = 3'd4;
  localparam logic [2:0] REQ_READ       = 3'd5;

  // Configuration register indexes (byte address / 4)
  localparam logic [2:0] CFG_FIRST_CHAR = 3'd0;
  localparam logic [2:0] CFG_LAST_CHAR  = 3'd1;
  localparam logic [2:0] CFG_HEIGHT     = 3'd2;
  localparam logic [2:0] CFG_SPACE      = 3'd3;
  localparam logic [2:0] CFG_SPACING    = 3'd4;

  localparam int unsigned APB_AW = 5;
  localparam logic [7:0] SPACE_CODE = 8'd32;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [11:0] addr;
    logic [7:0]  glyph_width;
    logic [11:0] glyph_offset;
    logic [7:0]  data_byte;
    logic [7:0]  new_cursor_x;
    logic [2:0]  new_cursor_page;
    logic [7:0]  char_code;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic [7:0] cursor_x_now;
    logic       char_drawn;
  } out_item_t;

  typedef struct packed {
    logic [7:0] first_char;
    logic [7:0] last_char;
    logic [3:0] height_pages;
    logic [7:0] space_width;
    logic [3:0] char_spacing;
  } cfg_t;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD_DESC,
    OP_LOAD_GLYPH,
    OP_SET_CURSOR,
    OP_SPACE,
    OP_DRAW,
    OP_CLEAR,
    OP_READ
  } op_e;

  typedef struct packed {
    op_e         op;
    logic [11:0] addr;
    logic [7:0]  width;
    logic [11:0] offset;
    logic [7:0]  data;
    logic [7:0]  cur_x;
    logic [2:0]  cur_page;
    logic [7:0]  idx;
  } cmd_t;

  // Add to the cursor, saturate at 255
  function automatic logic [7:0] sat_add(input logic [7:0] a, input logic [8:0] b);
    logic [9:0] s;
    s = {2'b00, a} + {1'b0, b};
    return (s > 10'd255) ? 8'd255 : s[7:0];
  endfunction

endpackage

>>> hw/rtl/gbf_ram.sv
// ----------------------------------------------------------------------------
// gbf_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module gbf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, then register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/gbf_queue.sv
// ----------------------------------------------------------------------------
// gbf_queue
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module gbf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  gbf_pkg::cmd_t push_cmd_i,
  input  logic          pop_i,
  output gbf_pkg::cmd_t head_o,
  output logic          empty_o,
  output logic          full_o
);
  import gbf_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign empty_o = (count_q == 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign head_o  = slot_q[rd_ptr_q];

  // Advance pointers and count
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed command
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

>>> hw/rtl/gbf_front.sv
// ----------------------------------------------------------------------------
// gbf_front
// Accepts requests, checks ranges and the font window, classifies them.
// ----------------------------------------------------------------------------
module gbf_front #(
  parameter int unsigned DESCRIPTOR_DEPTH  = 256,
  parameter int unsigned GLYPH_STORE_DEPTH = 4096,
  parameter int unsigned FB_BYTES          = 512
) (
  input  logic              in_valid_i,
  input  gbf_pkg::in_item_t in_item_i,
  input  gbf_pkg::cfg_t     cfg_i,
  input  logic              queue_full_i,
  input  logic              init_busy_i,
  output logic              in_stall_o,
  output logic              push_o,
  output gbf_pkg::cmd_t     cmd_o
);
  import gbf_pkg::*;

  logic [7:0] idx;
  logic       in_font;

  assign in_stall_o = queue_full_i | init_busy_i;
  assign push_o     = in_valid_i & ~in_stall_o;

  // Font window check
  assign idx     = in_item_i.char_code - cfg_i.first_char;
  assign in_font = (in_item_i.char_code >= cfg_i.first_char) &&
                   (in_item_i.char_code <= cfg_i.last_char) &&
                   (32'(idx) < DESCRIPTOR_DEPTH);

  // Classify the request
  always_comb begin
    cmd_o.addr     = in_item_i.addr;
    cmd_o.width    = in_item_i.glyph_width;
    cmd_o.offset   = in_item_i.glyph_offset;
    cmd_o.data     = in_item_i.data_byte;
    cmd_o.cur_x    = in_item_i.new_cursor_x;
    cmd_o.cur_page = in_item_i.new_cursor_page;
    cmd_o.idx      = idx;
    case (in_item_i.req_type)
      REQ_LOAD_DESC: begin
        cmd_o.op = (32'(in_item_i.addr) < DESCRIPTOR_DEPTH) ? OP_LOAD_DESC : OP_NOP;
      end
      REQ_LOAD_GLYPH: begin
        cmd_o.op = (32'(in_item_i.addr) < GLYPH_STORE_DEPTH) ? OP_LOAD_GLYPH : OP_NOP;
      end
      REQ_SET_CURSOR: cmd_o.op = OP_SET_CURSOR;
      REQ_DRAW: begin
        if (in_item_i.char_code == SPACE_CODE) begin
          cmd_o.op = OP_SPACE;
        end else begin
          cmd_o.op = in_font ? OP_DRAW : OP_NOP;
        end
      end
      REQ_CLEAR: cmd_o.op = OP_CLEAR;
      REQ_READ: begin
        cmd_o.op = (32'(in_item_i.addr) < FB_BYTES) ? OP_READ : OP_NOP;
      end
      default: cmd_o.op = OP_NOP;
    endcase
  end

endmodule

>>> hw/rtl/gbf_back.sv
// ----------------------------------------------------------------------------
// gbf_back
// Executes commands: table loads, cursor, frame clear, read, glyph blit.
// ----------------------------------------------------------------------------
module gbf_back #(
  parameter int unsigned FRAME_WIDTH       = 128,
  parameter int unsigned FRAME_HEIGHT      = 32,
  parameter int unsigned GLYPH_STORE_DEPTH = 4096,
  parameter int unsigned DESCRIPTOR_DEPTH  = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gbf_pkg::cfg_t      cfg_i,
  input  logic               q_empty_i,
  input  gbf_pkg::cmd_t      q_head_i,
  output logic               q_pop_o,
  output logic               init_busy_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output gbf_pkg::out_item_t out_item_o
);
  import gbf_pkg::*;

  localparam int unsigned PAGE_COUNT = FRAME_HEIGHT / 8;
  localparam int unsigned FB_BYTES   = FRAME_WIDTH * PAGE_COUNT;
  localparam int unsigned FB_AW      = $clog2(FB_BYTES);
  localparam int unsigned GA_W       = $clog2(GLYPH_STORE_DEPTH);
  localparam int unsigned DT_AW      = $clog2(DESCRIPTOR_DEPTH);
  localparam int unsigned RB_W       = 12;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_CLEAR, S_FBRD, S_DESC, S_OFFS, S_PAGE, S_RD, S_WR, S_DONE
  } state_e;

  state_e      state_q;
  logic [7:0]  cur_x_q;
  logic [2:0]  cur_row_q;
  logic [7:0]  width_q;
  logic [11:0] offs_q;
  logic [GA_W-1:0] ga_q;
  logic [GA_W-1:0] page_base_q;
  logic [3:0]  page_q;
  logic [4:0]  row_q;
  logic [8:0]  col_q;
  logic [8:0]  ncol_q;
  logic [RB_W-1:0] row_base_q;
  logic [FB_AW:0]  clr_q;
  logic [7:0]  rd_q;
  logic        drawn_q;
  logic        out_valid_q;
  out_item_t   out_q;

  logic             fb_we, dt_we, gs_we;
  logic [FB_AW-1:0] fb_addr;
  logic [7:0]       fb_wdata, fb_rdata;
  logic [DT_AW-1:0] dt_addr;
  logic [19:0]      dt_wdata, dt_rdata;
  logic [GA_W-1:0]  gs_addr;
  logic [7:0]       gs_rdata;
  logic [12:0]      pix_sum;
  logic [GA_W:0]    ga_inc, base_next;
  logic [8:0]       avail, ncol_new;
  logic             out_free;

  assign q_pop_o     = (state_q == S_IDLE) && !q_empty_i;
  assign init_busy_o = (state_q == S_INIT);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Address arithmetic of the blit walk
  assign pix_sum   = 13'(row_base_q) + 13'(cur_x_q) + 13'(col_q);
  assign ga_inc    = {1'b0, ga_q} + 1'b1;
  assign base_next = {1'b0, page_base_q} + (GA_W+1)'(width_q);
  assign avail     = 9'(FRAME_WIDTH) - {1'b0, cur_x_q};
  assign ncol_new  = (32'(cur_x_q) >= FRAME_WIDTH) ? 9'd0 :
                     ((avail < {1'b0, dt_rdata[7:0]}) ? avail : {1'b0, dt_rdata[7:0]});

  // Steer the memory ports
  always_comb begin
    fb_we    = 1'b0;
    fb_addr  = FB_AW'(pix_sum);
    fb_wdata = fb_rdata | gs_rdata;
    dt_we    = 1'b0;
    dt_addr  = DT_AW'(q_head_i.idx);
    dt_wdata = {q_head_i.offset, q_head_i.width};
    gs_we    = 1'b0;
    gs_addr  = ga_q;
    case (state_q)
      S_INIT, S_CLEAR: begin
        fb_we    = 1'b1;
        fb_addr  = FB_AW'(clr_q);
        fb_wdata = 8'd0;
      end
      S_IDLE: begin
        if (!q_empty_i) begin
          fb_addr = FB_AW'(q_head_i.addr);
          gs_addr = GA_W'(q_head_i.addr);
          if (q_head_i.op == OP_LOAD_DESC) begin
            dt_addr = DT_AW'(q_head_i.addr);
            dt_we   = 1'b1;
          end
          gs_we = (q_head_i.op == OP_LOAD_GLYPH);
        end
      end
      S_WR: fb_we = 1'b1;
      default: ;
    endcase
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      cur_x_q     <= 8'd0;
      cur_row_q   <= 3'd0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != S_DONE) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_INIT, S_CLEAR: begin
          if (32'(clr_q) == FB_BYTES - 1) begin
            clr_q   <= '0;
            state_q <= (state_q == S_INIT) ? S_IDLE : S_DONE;
          end else begin
            clr_q <= clr_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (!q_empty_i) begin
            rd_q    <= 8'd0;
            drawn_q <= (q_head_i.op == OP_SPACE);
            case (q_head_i.op)
              OP_SET_CURSOR: begin
                cur_x_q   <= q_head_i.cur_x;
                cur_row_q <= q_head_i.cur_page;
                state_q   <= S_DONE;
              end
              OP_SPACE: begin
                cur_x_q <= sat_add(cur_x_q, {1'b0, cfg_i.space_width});
                state_q <= S_DONE;
              end
              OP_DRAW:  state_q <= S_DESC;
              OP_CLEAR: state_q <= S_CLEAR;
              OP_READ:  state_q <= S_FBRD;
              default:  state_q <= S_DONE;
            endcase
          end
        end
        S_FBRD: begin
          rd_q    <= fb_rdata;
          state_q <= S_DONE;
        end
        S_DESC: begin
          if (dt_rdata[7:0] == 8'd0) begin
            state_q <= S_DONE;
          end else begin
            width_q    <= dt_rdata[7:0];
            offs_q     <= dt_rdata[19:8];
            ncol_q     <= ncol_new;
            page_q     <= 4'd0;
            row_q      <= {2'b00, cur_row_q};
            row_base_q <= RB_W'(cur_row_q * FRAME_WIDTH);
            state_q    <= S_OFFS;
          end
        end
        S_OFFS: begin
          // Reduce the start address into the glyph store
          if (32'(offs_q) >= GLYPH_STORE_DEPTH) begin
            offs_q <= offs_q - 12'(GLYPH_STORE_DEPTH);
          end else begin
            page_base_q <= GA_W'(offs_q);
            state_q     <= S_PAGE;
          end
        end
        S_PAGE: begin
          if (page_q >= cfg_i.height_pages || 32'(row_q) >= PAGE_COUNT ||
              ncol_q == 9'd0) begin
            cur_x_q <= sat_add(cur_x_q, {1'b0, width_q} + 9'(cfg_i.char_spacing));
            drawn_q <= 1'b1;
            state_q <= S_DONE;
          end else begin
            col_q   <= 9'd0;
            ga_q    <= page_base_q;
            state_q <= S_RD;
          end
        end
        S_RD: state_q <= S_WR;
        S_WR: begin
          col_q <= col_q + 1'b1;
          ga_q  <= (32'(ga_inc) == GLYPH_STORE_DEPTH) ? '0 : GA_W'(ga_inc);
          if (col_q + 1'b1 == ncol_q) begin
            // Next page row: skip clipped columns through the page base
            page_q      <= page_q + 1'b1;
            row_q       <= row_q + 1'b1;
            row_base_q  <= row_base_q + RB_W'(FRAME_WIDTH);
            page_base_q <= (32'(base_next) >= GLYPH_STORE_DEPTH) ?
                           GA_W'(base_next - (GA_W+1)'(GLYPH_STORE_DEPTH)) :
                           GA_W'(base_next);
            state_q     <= S_PAGE;
          end else begin
            state_q <= S_RD;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_q.read_byte    <= rd_q;
            out_q.cursor_x_now <= cur_x_q;
            out_q.char_drawn   <= drawn_q;
            out_valid_q        <= 1'b1;
            state_q            <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  gbf_ram #(.WIDTH(8), .DEPTH(FB_BYTES)) u_frame (
    .clk_i(clk_i), .we_i(fb_we), .addr_i(fb_addr), .wdata_i(fb_wdata), .rdata_o(fb_rdata)
  );

  gbf_ram #(.WIDTH(20), .DEPTH(DESCRIPTOR_DEPTH)) u_desc (
    .clk_i(clk_i), .we_i(dt_we), .addr_i(dt_addr), .wdata_i(dt_wdata), .rdata_o(dt_rdata)
  );

  gbf_ram #(.WIDTH(8), .DEPTH(GLYPH_STORE_DEPTH)) u_glyph (
    .clk_i(clk_i), .we_i(gs_we), .addr_i(gs_addr), .wdata_i(q_head_i.data),
    .rdata_o(gs_rdata)
  );

endmodule

>>> hw/rtl/glyph_blit_framebuffer.sv
// Request flow: loads, cursor, space and undrawable codes go from idle to the result;
// reads and zero-width glyphs pass a lookup state first; a draw looks up the descriptor,
// reduces the offset, then per page reads and writes each visible column; a clear writes
// every frame byte. One request runs at a time, the next starts as its result issues;
// the frame RAM read-modify-write of each glyph byte sets the draw rate.
// Reset: a pass clears all FRAME_WIDTH * FRAME_HEIGHT / 8 bytes; requests stall in it.
// ----------------------------------------------------------------------------
// glyph_blit_framebuffer
// Bitmap font text renderer over a page-organized monochrome frame buffer.
// ----------------------------------------------------------------------------
module glyph_blit_framebuffer #(
  parameter int unsigned FRAME_WIDTH       = 128,
  parameter int unsigned FRAME_HEIGHT      = 32,
  parameter int unsigned GLYPH_STORE_DEPTH = 4096,
  parameter int unsigned DESCRIPTOR_DEPTH  = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  gbf_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output gbf_pkg::out_item_t          out_item_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gbf_pkg::APB_AW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import gbf_pkg::*;

  cfg_t cfg_q;
  cmd_t push_cmd, q_head;
  logic push, pop, q_empty, q_full, init_busy;

  assign pready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.first_char   <= 8'd32;
      cfg_q.last_char    <= 8'd126;
      cfg_q.height_pages <= 4'd1;
      cfg_q.space_width  <= 8'd4;
      cfg_q.char_spacing <= 4'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        CFG_FIRST_CHAR: cfg_q.first_char   <= pwdata[7:0];
        CFG_LAST_CHAR:  cfg_q.last_char    <= pwdata[7:0];
        CFG_HEIGHT:     cfg_q.height_pages <= pwdata[3:0];
        CFG_SPACE:      cfg_q.space_width  <= pwdata[7:0];
        CFG_SPACING:    cfg_q.char_spacing <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  // Read back configuration registers
  always_comb begin
    case (paddr[4:2])
      CFG_FIRST_CHAR: prdata = {24'd0, cfg_q.first_char};
      CFG_LAST_CHAR:  prdata = {24'd0, cfg_q.last_char};
      CFG_HEIGHT:     prdata = {28'd0, cfg_q.height_pages};
      CFG_SPACE:      prdata = {24'd0, cfg_q.space_width};
      CFG_SPACING:    prdata = {28'd0, cfg_q.char_spacing};
      default:        prdata = 32'd0;
    endcase
  end

  gbf_front #(
    .DESCRIPTOR_DEPTH (DESCRIPTOR_DEPTH),
    .GLYPH_STORE_DEPTH(GLYPH_STORE_DEPTH),
    .FB_BYTES         (FRAME_WIDTH * (FRAME_HEIGHT / 8))
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .cfg_i       (cfg_q),
    .queue_full_i(q_full),
    .init_busy_i (init_busy),
    .in_stall_o  (in_stall_o),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  gbf_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_cmd_i(push_cmd),
    .pop_i     (pop),
    .head_o    (q_head),
    .empty_o   (q_empty),
    .full_o    (q_full)
  );

  gbf_back #(
    .FRAME_WIDTH      (FRAME_WIDTH),
    .FRAME_HEIGHT     (FRAME_HEIGHT),
    .GLYPH_STORE_DEPTH(GLYPH_STORE_DEPTH),
    .DESCRIPTOR_DEPTH (DESCRIPTOR_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_empty_i  (q_empty),
    .q_head_i   (q_head),
    .q_pop_o    (pop),
    .init_busy_o(init_busy),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the glyph blit frame buffer: a queue-fed driver
// sends requests, a predictor keeps a shadow frame buffer, font tables and
// cursor, and a monitor compares every result with the oldest expected one.
// ----------------------------------------------------------------------------
module tb;
  import gbf_pkg::*;

  localparam int FW = 128;
  localparam int PAGES = 4;
  localparam int FB_BYTES = FW * PAGES;
  localparam int GS_DEPTH = 4096;
  localparam int DESC_DEPTH = 256;
  localparam int WATCH_LIMIT = 40000;
  // Written glyph window: the low bytes plus a few at the top of the store
  localparam int GS_FILL_LOW = 480;
  localparam int GS_FILL_HIGH = 32;
  // Offsets up to this keep reads in the low window (width 12, four pages)
  localparam int OFF_MAX = 431;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  glyph_blit_framebuffer u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_item_i(in_item_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_item_o(out_item_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Shadow state of the renderer
  logic [7:0]  fb_shadow [FB_BYTES];
  logic [19:0] desc_shadow [DESC_DEPTH];
  logic [7:0]  glyph_shadow [GS_DEPTH];
  bit          desc_known [DESC_DEPTH];
  logic [7:0]  cur_col;
  logic [2:0]  cur_row;
  cfg_t        font_cfg;

  in_item_t  pending_reqs[$];
  out_item_t expected_results[$];
  int        mismatches = 0;
  int        idle_cycles = 0;
  int        hold_off = 0;
  int        results_seen = 0;
  bit        driver_done = 1'b0;
  int        send_gap = 0;
  int        recv_gap = 0;

  function automatic logic [7:0] add_sat(logic [7:0] a, int b);
    int s;
    s = a + b;
    return (s > 255) ? 8'd255 : s[7:0];
  endfunction

  // Work out the result of one request and update the shadow state
  function automatic out_item_t render_step(in_item_t r);
    out_item_t o;
    int idx, w, off, row, x;
    o = '0;
    case (r.req_type)
      REQ_LOAD_DESC: if (r.addr < DESC_DEPTH) begin
        desc_shadow[r.addr] = {r.glyph_offset, r.glyph_width};
        desc_known[r.addr] = 1'b1;
      end
      REQ_LOAD_GLYPH: glyph_shadow[r.addr] = r.data_byte;
      REQ_SET_CURSOR: begin
        cur_col = r.new_cursor_x;
        cur_row = r.new_cursor_page;
      end
      REQ_DRAW: begin
        if (r.char_code == SPACE_CODE) begin
          cur_col = add_sat(cur_col, font_cfg.space_width);
          o.char_drawn = 1'b1;
        end else if (r.char_code >= font_cfg.first_char &&
                     r.char_code <= font_cfg.last_char) begin
          idx = r.char_code - font_cfg.first_char;
          w = desc_shadow[idx][7:0];
          off = desc_shadow[idx][19:8];
          if (w != 0) begin
            for (int p = 0; p < font_cfg.height_pages; p++) begin
              row = cur_row + p;
              if (row >= PAGES) break;
              for (int c = 0; c < w; c++) begin
                x = cur_col + c;
                if (x >= FW) break;
                fb_shadow[row * FW + x] |= glyph_shadow[(off + p * w + c) % GS_DEPTH];
              end
            end
            cur_col = add_sat(cur_col, w + font_cfg.char_spacing);
            o.char_drawn = 1'b1;
          end
        end
      end
      REQ_CLEAR: foreach (fb_shadow[i]) fb_shadow[i] = '0;
      REQ_READ: if (r.addr < FB_BYTES) o.read_byte = fb_shadow[r.addr];
      default: ;
    endcase
    o.cursor_x_now = cur_col;
    return o;
  endfunction

  // Pick a draw code whose descriptor has been loaded, or a space or noise
  function automatic logic [7:0] pick_code();
    int k;
    logic [7:0] c;
    k = $urandom_range(0, 9);
    if (k == 0) return SPACE_CODE;
    if (k == 1) begin
      c = 8'($urandom);
      // keep codes inside the font range pointed at loaded descriptors
      if (c < font_cfg.first_char || c > font_cfg.last_char || desc_known[c - font_cfg.first_char])
        return c;
    end
    for (int t = 0; t < 20; t++) begin
      c = 8'(font_cfg.first_char +
             $urandom_range(0, font_cfg.last_char - font_cfg.first_char));
      if (c == SPACE_CODE || desc_known[c - font_cfg.first_char]) return c;
    end
    return SPACE_CODE;
  endfunction

  // Queue one request, predicting its result at queue time
  task automatic push_req(in_item_t r);
    pending_reqs.push_back(r);
    expected_results.push_back(render_step(r));
  endtask

  function automatic in_item_t make_req(logic [2:0] kind);
    in_item_t r;
    r = in_item_t'({$urandom, $urandom});
    r.req_type = kind;
    return r;
  endfunction

  task automatic load_desc(int a, int w, int off);
    in_item_t r;
    r = make_req(REQ_LOAD_DESC);
    r.addr = 12'(a); r.glyph_width = 8'(w); r.glyph_offset = 12'(off);
    push_req(r);
  endtask

  task automatic set_cursor(int x, int p);
    in_item_t r;
    r = make_req(REQ_SET_CURSOR);
    r.new_cursor_x = 8'(x); r.new_cursor_page = 3'(p);
    push_req(r);
  endtask

  task automatic draw(logic [7:0] code);
    in_item_t r;
    r = make_req(REQ_DRAW);
    r.char_code = code;
    push_req(r);
  endtask

  task automatic read_fb(int a);
    in_item_t r;
    r = make_req(REQ_READ);
    r.addr = 12'(a);
    push_req(r);
  endtask

  // Write one register through the APB port
  task automatic cfg_write(logic [2:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= APB_AW'(idx) << 2; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      CFG_FIRST_CHAR: font_cfg.first_char = val[7:0];
      CFG_LAST_CHAR:  font_cfg.last_char = val[7:0];
      CFG_HEIGHT:     font_cfg.height_pages = val[3:0];
      CFG_SPACE:      font_cfg.space_width = val[7:0];
      CFG_SPACING:    font_cfg.char_spacing = val[3:0];
      default: ;
    endcase
  endtask

  // Let the block drain before touching registers
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_results.size() != 0) @(posedge clk_i);
    repeat (3000) @(posedge clk_i);
  endtask

  task automatic cfg_all(int first, int last, int h, int sp, int cs);
    wait_drained();
    cfg_write(CFG_FIRST_CHAR, first);
    cfg_write(CFG_LAST_CHAR, last);
    cfg_write(CFG_HEIGHT, h);
    cfg_write(CFG_SPACE, sp);
    cfg_write(CFG_SPACING, cs);
  endtask

  // Random phase: mostly table loads, draws and frame reads, with noise mixed in
  task automatic random_phase(int n);
    in_item_t r;
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 10) load_desc($urandom_range(0, 20) + (font_cfg.first_char % 4),
                            $urandom_range(0, 12), $urandom_range(0, OFF_MAX));
      else if (k < 13) load_desc($urandom_range(DESC_DEPTH, 4095), $urandom_range(0, 255),
                                 $urandom_range(0, 4095));
      else if (k < 28) begin
        r = make_req(REQ_LOAD_GLYPH);
        push_req(r);
      end else if (k < 36) set_cursor($urandom, $urandom);
      else if (k < 62) draw(pick_code());
      else if (k < 64) push_req(make_req(REQ_CLEAR));
      else if (k < 92) read_fb($urandom_range(0, FB_BYTES - 1));
      else if (k < 95) read_fb($urandom);
      else begin
        r = make_req(3'($urandom_range(6, 7)));
        push_req(r);
      end
    end
  endtask

  // Stimulus
  initial begin
    font_cfg = '{first_char: 32, last_char: 126, height_pages: 1,
                 space_width: 4, char_spacing: 1};
    foreach (fb_shadow[i]) fb_shadow[i] = '0;
    foreach (desc_shadow[i]) desc_shadow[i] = '0;
    foreach (glyph_shadow[i]) glyph_shadow[i] = '0;
    foreach (desc_known[i]) desc_known[i] = 1'b0;
    cur_col = '0;
    cur_row = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Fill the glyph window that every descriptor points into
    for (int a = 0; a < GS_DEPTH; a += 1) begin
      in_item_t r;
      if (a >= GS_FILL_LOW && a < GS_DEPTH - GS_FILL_HIGH) continue;
      r = make_req(REQ_LOAD_GLYPH);
      r.addr = 12'(a);
      r.data_byte = (a < 16) ? 8'hFF : 8'($urandom);
      if (a < 2) r.data_byte = a ? 8'h00 : 8'hFF;
      push_req(r);
    end
    // Directed: extremes, special cases
    load_desc(1, 3, 0);            // '!'
    load_desc(2, 0, 5);            // zero width '"'
    load_desc(3, 255, 4094);       // widest, wraps the store
    load_desc(4095, 9, 9);         // out of range index, ignored
    draw("!");
    draw(" ");
    draw("\"");                    // zero width
    draw(8'd0);                    // below font
    draw(8'd255);                  // above font
    set_cursor(126, 3);            // right clip on the bottom page
    draw("!");
    read_fb(3 * FW + 127);
    set_cursor(0, 7);              // row below frame
    draw("!");
    set_cursor(0, 2);
    draw("#");                     // wrap through the top of the store
    set_cursor(250, 0);
    draw("#");                     // saturate cursor
    read_fb(0);
    read_fb(FB_BYTES);             // out of range read
    read_fb(4095);
    push_req(make_req(3'd7));
    push_req(make_req(REQ_CLEAR));
    read_fb(1);

    cfg_all(0, 255, 8, 255, 15);
    for (int i = 0; i < 6; i++) load_desc(i, $urandom_range(1, 8), $urandom_range(0, OFF_MAX));
    random_phase(150);
    cfg_all(255, 0, 0, 0, 0);
    random_phase(50);
    cfg_all(30, 60, 3, 7, 2);
    random_phase(130);
    cfg_all(32, 126, 1, 4, 1);
    random_phase(130);
    wait (pending_reqs.size() == 0);
    driver_done = 1'b1;
  end

  // Driver: offer pending requests with random gaps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        void'(pending_reqs.pop_front());
        send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
      end
      if (!(in_valid_i && in_stall_o)) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_reqs.size() > 0 && !(in_valid_i && !in_stall_o &&
                     pending_reqs.size() == 0)) begin
          in_valid_i <= 1'b1;
          in_item_i <= pending_reqs[0];
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic report(string what, out_item_t e, out_item_t g);
    $display("mismatch %s: expected %h got %h at %0t", what, e, g, $time);
    mismatches++;
  endtask

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) report("unexpected result", '0, out_item_o);
        else begin
          out_item_t e;
          e = expected_results.pop_front();
          if (e.read_byte !== out_item_o.read_byte) report("read_byte", e, out_item_o);
          if (e.cursor_x_now !== out_item_o.cursor_x_now) report("cursor_x_now", e, out_item_o);
          if (e.char_drawn !== out_item_o.char_drawn) report("char_drawn", e, out_item_o);
        end
        results_seen++;
        recv_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        // Hold off for a long stretch once for sure, and now and then at random
        if (hold_off == 0 && (results_seen == 600 || $urandom_range(0, 299) == 0))
          hold_off = 200;
      end
      if (hold_off > 0) begin
        hold_off--;
        out_stall_i <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog and end of run
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  initial begin
    wait (driver_done && expected_results.size() == 0);
    repeat (3000) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/gbf_pkg.sv
hw/rtl/gbf_ram.sv
hw/rtl/gbf_queue.sv
hw/rtl/gbf_front.sv
hw/rtl/gbf_back.sv
hw/rtl/glyph_blit_framebuffer.sv
sim/tb.sv
